// ===== rtl/core/wvp_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the wagner vapor pressure pipeline
// no dependencies

package wvp_pkg;

  localparam int TEMP_W      = 20;
  localparam int COEFF_W     = 22;
  localparam int PC_W        = 28;
  localparam int PRES_W      = 36;
  localparam int TAU_W       = 30;
  localparam int POLY_W      = 32;
  localparam int MAG_W       = 51;
  localparam int N_TERMS     = 12;
  localparam int COEFF_FRAC_BITS = 16;
  localparam int POLY_SHIFT  = COEFF_FRAC_BITS + TAU_W - 24;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
  localparam logic [29:0]        LN2_Q30   = 30'd744261118;
  localparam logic [PRES_W-1:0]  PRES_MAX  = {PRES_W{1'b1}};

  // floor(2^32 / k) for the series divisions
  localparam logic [32:0] RECIP [1:N_TERMS] = '{
    33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
    33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
    33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941
  };

  typedef enum logic [2:0] {
    REG_COEFF_A   = 3'd0,
    REG_COEFF_B   = 3'd1,
    REG_COEFF_C   = 3'd2,
    REG_COEFF_D   = 3'd3,
    REG_CRIT_P    = 3'd4,
    REG_CRIT_T    = 3'd5
  } reg_idx_t;

  // sideband that travels with every item
  typedef struct packed {
    logic              vld;
    logic              zt;
    logic              ovf;
    logic              unf;
    logic [TEMP_W-1:0] tl;
  } side_t;

  typedef struct packed {
    logic [PRES_W-1:0] pressure;
    logic              saturated;
    logic              zero_temp;
  } res_t;

endpackage

// ===== rtl/core/wagner_vapor_pressure_eval_top.sv =====
`timescale 1ns / 1ps
// wagner 2.5-5 vapor pressure evaluator, fully pipelined
// depends on wvp_pkg

// One temperature beat in, one pressure beat out, in order. The block takes a
// new beat every cycle while the output buffer has room. The beat passes 160
// pipeline registers and then the output buffer, and the first register is
// loaded at the accepting edge itself. The depth is set by the bit-per-stage
// dividers for tau (30 stages) and for the Tc/T scaling (51 stages), the
// bit-per-stage square root (30 stages) and the twelve-term exp series (three
// stages per term). The whole pipeline advances together and holds while the
// two-entry output buffer is full, so a stalled result never loses or repeats
// a beat and the input keeps flowing while one result waits. Registers sit at
// byte address 4*index on the APB-style port and must only be written while
// the pipeline is empty.

module wagner_vapor_pressure_eval_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wvp_pkg::ADDR_W-1:0]        paddr,
  input  logic [wvp_pkg::DATA_W-1:0]        pwdata,
  output logic [wvp_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  input  logic                              temp_valid,
  output logic                              temp_stall,
  input  logic [wvp_pkg::TEMP_W-1:0]        temperature,
  output logic                              pres_valid,
  input  logic                              pres_stall,
  output logic [wvp_pkg::PRES_W-1:0]        pressure,
  output logic                              saturated,
  output logic                              zero_temp
);
  import wvp_pkg::*;

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic signed [COEFF_W-1:0] coeff_a, coeff_b, coeff_c, coeff_d;
  logic [PC_W-1:0]           crit_pressure;
  logic [TEMP_W-1:0]         crit_temperature;
  reg_idx_t                  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_a          <= '0;
      coeff_b          <= '0;
      coeff_c          <= '0;
      coeff_d          <= '0;
      crit_pressure    <= '0;
      crit_temperature <= {TEMP_W{1'b1}};
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_COEFF_A: coeff_a          <= pwdata[COEFF_W-1:0];
        REG_COEFF_B: coeff_b          <= pwdata[COEFF_W-1:0];
        REG_COEFF_C: coeff_c          <= pwdata[COEFF_W-1:0];
        REG_COEFF_D: coeff_d          <= pwdata[COEFF_W-1:0];
        REG_CRIT_P:  crit_pressure    <= pwdata[PC_W-1:0];
        REG_CRIT_T:  crit_temperature <= pwdata[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COEFF_A: prdata = {{(DATA_W-COEFF_W){1'b0}}, coeff_a};
      REG_COEFF_B: prdata = {{(DATA_W-COEFF_W){1'b0}}, coeff_b};
      REG_COEFF_C: prdata = {{(DATA_W-COEFF_W){1'b0}}, coeff_c};
      REG_COEFF_D: prdata = {{(DATA_W-COEFF_W){1'b0}}, coeff_d};
      REG_CRIT_P:  prdata = {{(DATA_W-PC_W){1'b0}}, crit_pressure};
      REG_CRIT_T:  prdata = {{(DATA_W-TEMP_W){1'b0}}, crit_temperature};
      default:     prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // global advance: the pipeline moves whenever the output buffer has room
  // ------------------------------------------------------------------
  logic [1:0] skid_cnt;
  logic       en;

  assign en         = (skid_cnt != 2'd2);
  assign temp_stall = !en;

  // ------------------------------------------------------------------
  // entry: clamp temperature to Tc, start tau = (Tc-Tl)/Tc division
  // ------------------------------------------------------------------
  side_t              d1_side [0:TAU_W];
  logic [TEMP_W-1:0]  d1_rem  [0:TAU_W];
  logic [TAU_W-1:0]   d1_q    [0:TAU_W];
  logic [TEMP_W-1:0]  tl_in;

  assign tl_in = (temperature < crit_temperature) ? temperature : crit_temperature;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_side[0].vld <= 1'b0;
    end else if (en) begin
      d1_side[0] <= '{vld: temp_valid, zt: (tl_in == '0), ovf: 1'b0, unf: 1'b0,
                      tl: tl_in};
      d1_rem[0]  <= crit_temperature - tl_in;
      d1_q[0]    <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < TAU_W; i++) begin : g_div1
    logic [TEMP_W:0] r2;
    logic            ge;
    assign r2 = {d1_rem[i], 1'b0};
    assign ge = (r2 >= {1'b0, crit_temperature});
    always_ff @(posedge clk) begin
      if (rst) begin
        d1_side[i+1].vld <= 1'b0;
      end else if (en) begin
        d1_side[i+1] <= d1_side[i];
        d1_rem[i+1]  <= ge ? TEMP_W'(r2 - {1'b0, crit_temperature}) : r2[TEMP_W-1:0];
        d1_q[i+1]    <= {d1_q[i][TAU_W-2:0], ge};
      end
    end
  end

  // ------------------------------------------------------------------
  // square root of tau, two radicand bits per stage
  // ------------------------------------------------------------------
  side_t             sq_side [1:TAU_W];
  logic [TAU_W-1:0]  sq_tau  [1:TAU_W];
  logic [31:0]       sq_rem  [1:TAU_W];
  logic [TAU_W-1:0]  sq_root [1:TAU_W];

  for (genvar i = 0; i < TAU_W; i++) begin : g_sqrt
    localparam int J = TAU_W - 1 - i;
    side_t              s_side;
    logic [TAU_W-1:0]   s_tau;
    logic [31:0]        s_rem;
    logic [TAU_W-1:0]   s_root;
    logic [2*TAU_W-1:0] vfull;
    logic [33:0]        sh34;
    logic [31:0]        trial;
    logic               ge;
    if (i == 0) begin : g_src
      assign s_side = d1_side[TAU_W];
      assign s_tau  = d1_q[TAU_W];
      assign s_rem  = '0;
      assign s_root = '0;
    end else begin : g_src
      assign s_side = sq_side[i];
      assign s_tau  = sq_tau[i];
      assign s_rem  = sq_rem[i];
      assign s_root = sq_root[i];
    end
    assign vfull = {s_tau, {TAU_W{1'b0}}};
    assign sh34  = {s_rem, vfull[2*J+1 -: 2]};
    assign trial = {s_root, 2'b01};
    assign ge    = (sh34 >= 34'(trial));
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_side[i+1].vld <= 1'b0;
      end else if (en) begin
        sq_side[i+1] <= s_side;
        sq_tau[i+1]  <= s_tau;
        sq_rem[i+1]  <= ge ? 32'(sh34 - 34'(trial)) : 32'(sh34);
        sq_root[i+1] <= {s_root[TAU_W-2:0], ge};
      end
    end
  end

  // ------------------------------------------------------------------
  // powers of tau: tau^1.5, tau^2, tau^2.5, tau^4, tau^5
  // ------------------------------------------------------------------
  side_t            m1_side, m2_side, m3_side;
  logic [TAU_W-1:0] m1_tau, m1_s, m1_t15, m1_t2;
  logic [TAU_W-1:0] m2_tau, m2_t15, m2_t25, m2_t4;
  logic [TAU_W-1:0] m3_tau, m3_t15, m3_t25, m3_t5;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_side.vld <= 1'b0;
      m2_side.vld <= 1'b0;
      m3_side.vld <= 1'b0;
    end else if (en) begin
      m1_side <= sq_side[TAU_W];
      m1_tau  <= sq_tau[TAU_W];
      m1_s    <= sq_root[TAU_W];
      m1_t15  <= TAU_W'((60'(sq_tau[TAU_W]) * 60'(sq_root[TAU_W])) >> TAU_W);
      m1_t2   <= TAU_W'((60'(sq_tau[TAU_W]) * 60'(sq_tau[TAU_W])) >> TAU_W);

      m2_side <= m1_side;
      m2_tau  <= m1_tau;
      m2_t15  <= m1_t15;
      m2_t25  <= TAU_W'((60'(m1_t2) * 60'(m1_s)) >> TAU_W);
      m2_t4   <= TAU_W'((60'(m1_t2) * 60'(m1_t2)) >> TAU_W);

      m3_side <= m2_side;
      m3_tau  <= m2_tau;
      m3_t15  <= m2_t15;
      m3_t25  <= m2_t25;
      m3_t5   <= TAU_W'((60'(m2_t4) * 60'(m2_tau)) >> TAU_W);
    end
  end

  // ------------------------------------------------------------------
  // polynomial A*tau + B*tau^1.5 + C*tau^2.5 + D*tau^5, then times Tc
  // ------------------------------------------------------------------
  side_t              p1_side, p2_side, p3_side, p4_side;
  logic signed [52:0] pr_a, pr_b, pr_c, pr_d;
  logic signed [54:0] s01, s23;
  logic signed [54:0] psum;
  logic signed [POLY_W-1:0] poly;
  logic signed [52:0] pv;

  assign psum = s01 + s23;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_side.vld <= 1'b0;
      p2_side.vld <= 1'b0;
      p3_side.vld <= 1'b0;
      p4_side.vld <= 1'b0;
    end else if (en) begin
      p1_side <= m3_side;
      pr_a    <= 53'(coeff_a) * 53'($signed({1'b0, m3_tau}));
      pr_b    <= 53'(coeff_b) * 53'($signed({1'b0, m3_t15}));
      pr_c    <= 53'(coeff_c) * 53'($signed({1'b0, m3_t25}));
      pr_d    <= 53'(coeff_d) * 53'($signed({1'b0, m3_t5}));

      p2_side <= p1_side;
      s01     <= 55'(pr_a) + 55'(pr_b);
      s23     <= 55'(pr_c) + 55'(pr_d);

      p3_side <= p2_side;
      poly    <= POLY_W'(psum >>> POLY_SHIFT);

      p4_side <= p3_side;
      pv      <= 53'(poly) * 53'($signed({1'b0, crit_temperature}));
    end
  end

  // ------------------------------------------------------------------
  // x = floor(poly*Tc / Tl): sign-magnitude division, one bit per stage
  // ------------------------------------------------------------------
  side_t             d2_side [0:MAG_W];
  logic [MAG_W-1:0]  d2_mag  [0:MAG_W];
  logic              d2_sgn  [0:MAG_W];
  logic [TEMP_W-1:0] d2_rem  [0:MAG_W];
  logic [MAG_W-1:0]  d2_q    [0:MAG_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_side[0].vld <= 1'b0;
    end else if (en) begin
      d2_side[0] <= p4_side;
      d2_sgn[0]  <= pv[52];
      d2_mag[0]  <= MAG_W'(pv[52] ? -pv : pv);
      d2_rem[0]  <= '0;
      d2_q[0]    <= '0;
    end
  end

  for (genvar i = 0; i < MAG_W; i++) begin : g_div2
    logic [TEMP_W:0] r2;
    logic            ge;
    assign r2 = {d2_rem[i], d2_mag[i][MAG_W-1-i]};
    assign ge = (r2 >= {1'b0, d2_side[i].tl});
    always_ff @(posedge clk) begin
      if (rst) begin
        d2_side[i+1].vld <= 1'b0;
      end else if (en) begin
        d2_side[i+1] <= d2_side[i];
        d2_sgn[i+1]  <= d2_sgn[i];
        d2_mag[i+1]  <= d2_mag[i];
        d2_rem[i+1]  <= ge ? TEMP_W'(r2 - {1'b0, d2_side[i].tl}) : r2[TEMP_W-1:0];
        d2_q[i+1]    <= {d2_q[i][MAG_W-2:0], ge};
      end
    end
  end

  // floor for negatives, range check against +/-64 in Q.24
  side_t            x1_side;
  logic signed [30:0] x1_x;
  logic [MAG_W:0]   mag_up;
  logic             x_sgn;
  logic [MAG_W-1:0] x_q;

  assign x_sgn  = d2_sgn[MAG_W];
  assign x_q    = d2_q[MAG_W];
  assign mag_up = (MAG_W+1)'(x_q) + (MAG_W+1)'(d2_rem[MAG_W] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_side.vld <= 1'b0;
    end else if (en) begin
      x1_side     <= '{vld: d2_side[MAG_W].vld, zt: d2_side[MAG_W].zt,
                       ovf: !x_sgn && (x_q[MAG_W-1:30] != '0),
                       unf: x_sgn && (mag_up[MAG_W:30] != '0),
                       tl: d2_side[MAG_W].tl};
      x1_x        <= x_sgn ? -$signed(mag_up[30:0]) : $signed(x_q[30:0]);
    end
  end

  // ------------------------------------------------------------------
  // exp(x) = 2^n * 2^f: y = x*log2(e), n integer part, g = f*ln2
  // ------------------------------------------------------------------
  side_t            e1_side;
  logic signed [31:0] e1_y;

  side_t            ts_side [0:N_TERMS];
  logic [7:0]       ts_n    [0:N_TERMS];
  logic [TAU_W-1:0] ts_g    [0:N_TERMS];
  logic [TAU_W:0]   ts_term [0:N_TERMS];
  logic [31:0]      ts_m    [0:N_TERMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_side.vld    <= 1'b0;
      ts_side[0].vld <= 1'b0;
    end else if (en) begin
      e1_side    <= x1_side;
      e1_y       <= 32'((63'(x1_x) * 63'(LOG2E_Q30)) >>> 30);

      ts_side[0] <= e1_side;
      ts_n[0]    <= e1_y[31:24];
      ts_g[0]    <= TAU_W'((54'(e1_y[23:0]) * 54'(LN2_Q30)) >> 24);
      ts_term[0] <= (TAU_W+1)'(1) << TAU_W;
      ts_m[0]    <= 32'(1) << TAU_W;
    end
  end

  // taylor series: per term a multiply, a reciprocal multiply, a fix-up add
  side_t            sa_side [1:N_TERMS];
  logic [7:0]       sa_n    [1:N_TERMS];
  logic [TAU_W-1:0] sa_g    [1:N_TERMS];
  logic [TAU_W-1:0] sa_v    [1:N_TERMS];
  logic [31:0]      sa_m    [1:N_TERMS];
  side_t            sb_side [1:N_TERMS];
  logic [7:0]       sb_n    [1:N_TERMS];
  logic [TAU_W-1:0] sb_g    [1:N_TERMS];
  logic [TAU_W-1:0] sb_v    [1:N_TERMS];
  logic [TAU_W-1:0] sb_q0   [1:N_TERMS];
  logic [31:0]      sb_m    [1:N_TERMS];

  for (genvar k = 1; k <= N_TERMS; k++) begin : g_term
    logic [TAU_W-1:0] r;
    logic             ge;
    logic [TAU_W-1:0] term;
    assign r    = sb_v[k] - (sb_q0[k] * TAU_W'(k));
    assign ge   = (r >= TAU_W'(k));
    assign term = sb_q0[k] + TAU_W'(ge);
    always_ff @(posedge clk) begin
      if (rst) begin
        sa_side[k].vld <= 1'b0;
        sb_side[k].vld <= 1'b0;
        ts_side[k].vld <= 1'b0;
      end else if (en) begin
        sa_side[k] <= ts_side[k-1];
        sa_n[k]    <= ts_n[k-1];
        sa_g[k]    <= ts_g[k-1];
        sa_m[k]    <= ts_m[k-1];
        sa_v[k]    <= TAU_W'((61'(ts_term[k-1]) * 61'(ts_g[k-1])) >> TAU_W);

        sb_side[k] <= sa_side[k];
        sb_n[k]    <= sa_n[k];
        sb_g[k]    <= sa_g[k];
        sb_m[k]    <= sa_m[k];
        sb_v[k]    <= sa_v[k];
        sb_q0[k]   <= TAU_W'((63'(sa_v[k]) * 63'(RECIP[k])) >> 32);

        ts_side[k] <= sb_side[k];
        ts_n[k]    <= sb_n[k];
        ts_g[k]    <= sb_g[k];
        ts_term[k] <= (TAU_W+1)'(term);
        ts_m[k]    <= sb_m[k] + 32'(term);
      end
    end
  end

  // ------------------------------------------------------------------
  // pc * 2^f, then shift by n-22 with saturation
  // ------------------------------------------------------------------
  side_t        f1_side;
  logic [7:0]   f1_n;
  logic [59:0]  f1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_side.vld <= 1'b0;
    end else if (en) begin
      f1_side <= ts_side[N_TERMS];
      f1_n    <= ts_n[N_TERMS];
      f1_prod <= 60'(crit_pressure) * 60'(ts_m[N_TERMS]);
    end
  end

  logic signed [8:0] sh;
  logic [8:0]        rsh;
  logic [5:0]        lamt;
  logic              left_over;
  logic [PRES_W-1:0] left_val;
  logic [59:0]       rval;
  res_t              res;

  assign sh        = {f1_n[7], f1_n} - 9'sd22;
  assign rsh       = -sh;
  assign lamt      = sh[5:0];
  assign left_over = ((f1_prod >> (6'd36 - lamt)) != '0);
  assign left_val  = PRES_W'(f1_prod << lamt);
  assign rval      = (rsh >= 9'd64) ? '0 : (f1_prod >> rsh[5:0]);

  always_comb begin
    res = '{pressure: '0, saturated: 1'b0, zero_temp: 1'b0};
    if (f1_side.zt) begin
      res.zero_temp = 1'b1;
    end else if (crit_pressure == '0) begin
      res.pressure = '0;
    end else if (f1_side.ovf) begin
      res.pressure  = PRES_MAX;
      res.saturated = 1'b1;
    end else if (f1_side.unf) begin
      res.pressure = '0;
    end else if (sh > 9'sd0) begin
      if (sh >= 9'sd36 || left_over) begin
        res.pressure  = PRES_MAX;
        res.saturated = 1'b1;
      end else begin
        res.pressure = left_val;
      end
    end else if (rval > 60'(PRES_MAX)) begin
      res.pressure  = PRES_MAX;
      res.saturated = 1'b1;
    end else begin
      res.pressure = PRES_W'(rval);
    end
  end

  // ------------------------------------------------------------------
  // two-entry output buffer, head drives the ports
  // ------------------------------------------------------------------
  res_t sk0, sk1;
  logic push, pop;

  assign push = en && f1_side.vld;
  assign pop  = pres_valid && !pres_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (skid_cnt == 2'd0) begin
            sk0 <= res;
          end else begin
            sk1 <= res;
          end
          skid_cnt <= skid_cnt + 2'd1;
        end
        2'b01: begin
          sk0      <= sk1;
          skid_cnt <= skid_cnt - 2'd1;
        end
        2'b11: begin
          if (skid_cnt == 2'd1) begin
            sk0 <= res;
          end else begin
            sk0 <= sk1;
            sk1 <= res;
          end
        end
        default: ;
      endcase
    end
  end

  assign pres_valid = (skid_cnt != 2'd0);
  assign pressure   = sk0.pressure;
  assign saturated  = sk0.saturated;
  assign zero_temp  = sk0.zero_temp;

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  a_skid_bound: assert property (@(posedge clk) disable iff (rst)
    skid_cnt != 2'd3)
    else $error("output buffer count out of range");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    pres_valid |-> !(saturated && zero_temp))
    else $error("saturated and zero_temp both set");

  a_zero_temp_p: assert property (@(posedge clk) disable iff (rst)
    (pres_valid && zero_temp) |-> (pressure == '0))
    else $error("zero temperature with nonzero pressure");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (skid_cnt == $past(skid_cnt) - 2'd1))
    else $error("output buffer count did not drop on pop");

endmodule

// ===== verif/wagner_vapor_pressure_eval_top_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the wagner vapor pressure evaluator
// predicts every pressure beat in fixed point; depends on wvp_pkg and the top level

module wagner_vapor_pressure_eval_top_tb;
  import wvp_pkg::*;

  localparam longint unsigned MASK36 = 64'hF_FFFF_FFFF;
  localparam longint X_LIMIT = 64'sd64 <<< 24;
  localparam longint LOG2E   = 64'sd1549082005;
  localparam longint LN2     = 64'sd744261118;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [PRES_W-1:0] pressure;
    logic              saturated;
    logic              zero_temp;
  } pres_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic temp_valid = 1'b0;
  logic temp_stall;
  logic [TEMP_W-1:0] temperature = '0;
  logic pres_valid;
  logic pres_stall = 1'b0;
  logic [PRES_W-1:0] pressure;
  logic saturated, zero_temp;

  wagner_vapor_pressure_eval_top u_top (.*);

  always #4 clk = ~clk;

  // bench copy of the register file
  longint          cfg_coeff [4];
  longint unsigned cfg_pc, cfg_tc;

  logic [TEMP_W-1:0] temp_pending [$];
  pres_beat_t        pres_expected [$];
  int  mismatches = 0;
  int  beats_in = 0, beats_out = 0, sat_seen = 0, zt_seen = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;

  // floor square root, one result bit at a time from the top
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, cand;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  function automatic longint div_floor(longint v, longint d);
    if (v >= 0) return v / d;
    return -((-v + d - 1) / d);
  endfunction

  // expected beat for one temperature under the current registers
  function automatic pres_beat_t wagner_pressure(logic [TEMP_W-1:0] temp);
    longint unsigned tl, tau, s, t15, t2, t25, t4, t5, f, g, term, m, prod;
    longint sum, poly, x, y, n, sh;
    pres_beat_t r;
    r = '{pressure: '0, saturated: 1'b0, zero_temp: 1'b0};
    tl = (temp < cfg_tc) ? temp : cfg_tc;
    if (tl == 0) begin
      r.zero_temp = 1'b1;
      return r;
    end
    if (cfg_pc == 0) return r;
    tau = ((cfg_tc - tl) << 30) / cfg_tc;
    s   = floor_sqrt(tau << 30);
    t15 = (tau * s) >> 30;
    t2  = (tau * tau) >> 30;
    t25 = (t2 * s) >> 30;
    t4  = (t2 * t2) >> 30;
    t5  = (t4 * tau) >> 30;
    sum = cfg_coeff[0] * longint'(tau) + cfg_coeff[1] * longint'(t15)
        + cfg_coeff[2] * longint'(t25) + cfg_coeff[3] * longint'(t5);
    poly = sum >>> (COEFF_FRAC_BITS + 6);
    x = div_floor(poly * longint'(cfg_tc), longint'(tl));
    if (x >= X_LIMIT) begin
      r.pressure = PRES_W'(MASK36);
      r.saturated = 1'b1;
      return r;
    end
    if (x <= -X_LIMIT) return r;
    y = (x * LOG2E) >>> 30;
    n = y >>> 24;
    f = longint'(y) & 64'hFF_FFFF;
    g = (f * LN2) >> 24;
    // twelve-term series for 2^frac
    term = 64'd1 << 30;
    m = term;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * g) >> 30) / k;
      m += term;
    end
    prod = cfg_pc * m;
    sh = n - 22;
    if (sh > 0) begin
      if (sh >= 36 || prod > (MASK36 >> sh)) begin
        r.pressure = PRES_W'(MASK36);
        r.saturated = 1'b1;
        return r;
      end
      prod = prod << sh;
    end else if (sh < 0) begin
      prod = (-sh >= 64) ? 0 : (prod >> (-sh));
    end
    if (prod > MASK36) begin
      r.pressure = PRES_W'(MASK36);
      r.saturated = 1'b1;
      return r;
    end
    r.pressure = PRES_W'(prod);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // driver: one temperature beat per cycle when not idling or stalled
  always @(posedge clk) begin
    if (rst) begin
      temp_valid <= 1'b0;
    end else begin
      if (temp_valid && !temp_stall) begin
        pres_expected.push_back(wagner_pressure(temperature));
        beats_in++;
      end
      if (!temp_valid || !temp_stall) begin
        if (temp_pending.size() > 0 && (no_idle || $urandom_range(99) >= 12)) begin
          temp_valid  <= 1'b1;
          temperature <= temp_pending.pop_front();
        end else begin
          temp_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin
    pres_beat_t e;
    if (rst) begin
      pres_stall <= 1'b0;
    end else begin
      if (pres_valid && !pres_stall) begin
        beats_out++;
        if (pres_expected.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          e = pres_expected.pop_front();
          if (pressure !== e.pressure)
            report_mismatch($sformatf("pressure got %0h want %0h", pressure, e.pressure));
          if (saturated !== e.saturated)
            report_mismatch($sformatf("saturated got %b want %b", saturated, e.saturated));
          if (zero_temp !== e.zero_temp)
            report_mismatch($sformatf("zero_temp got %b want %b", zero_temp, e.zero_temp));
          sat_seen += e.saturated;
          zt_seen  += e.zero_temp;
        end
      end
      pres_stall <= !no_idle && ($urandom_range(99) < 12);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // apb write: setup cycle then access cycle; mirror into the bench copy
  task automatic reg_write(int idx, longint value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4); pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_COEFF_A, REG_COEFF_B, REG_COEFF_C, REG_COEFF_D: begin
        cfg_coeff[idx] = longint'(signed'(value[COEFF_W-1:0]));
      end
      REG_CRIT_P: cfg_pc = value & 64'hFFF_FFFF;
      REG_CRIT_T: cfg_tc = value & 64'hF_FFFF;
      default: ;  // unmapped address, write dropped
    endcase
  endtask

  task automatic load_regs(longint a, longint b, longint c, longint d, longint pc, longint tc);
    reg_write(REG_COEFF_A, a);
    reg_write(REG_COEFF_B, b);
    reg_write(REG_COEFF_C, c);
    reg_write(REG_COEFF_D, d);
    reg_write(REG_CRIT_P, pc);
    reg_write(REG_CRIT_T, tc);
  endtask

  // sender pauses here until every predicted beat has drained
  task automatic drain();
    wait (temp_pending.size() == 0 && !temp_valid && pres_expected.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  // mostly below tc where the curve lives, some anywhere, some between tc/2 and tc
  task automatic queue_random(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(9);
      if (sel < 6 && cfg_tc > 1)
        temp_pending.push_back(TEMP_W'($urandom_range(32'(cfg_tc - 1), 1)));
      else if (sel < 8) temp_pending.push_back(TEMP_W'($urandom));
      else temp_pending.push_back(TEMP_W'($urandom_range(32'(cfg_tc), 32'(cfg_tc / 2))));
    end
  endtask

  function automatic longint rand_coeff();
    return longint'(signed'(COEFF_W'($urandom)));
  endfunction

  initial begin
    cfg_coeff = '{0, 0, 0, 0};
    cfg_pc = 0;
    cfg_tc = 64'hF_FFFF;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers: pc is zero so everything reads zero, except zero temperature
    temp_pending.push_back('0);
    temp_pending.push_back(TEMP_W'(1));
    temp_pending.push_back('1);
    queue_random(40);
    drain();

    // water-like constants, directed corners around the critical point
    load_regs(-515081, 120854, -772455, 1486406, 22064000, 662630);
    foreach (temp_pending[i]) ;
    temp_pending.push_back('0);
    temp_pending.push_back(TEMP_W'(1));
    temp_pending.push_back(TEMP_W'(2));
    temp_pending.push_back(TEMP_W'(273 * 1024));
    temp_pending.push_back(TEMP_W'(373 * 1024));
    temp_pending.push_back(TEMP_W'(662629));
    temp_pending.push_back(TEMP_W'(662630));
    temp_pending.push_back(TEMP_W'(662631));
    temp_pending.push_back(TEMP_W'(331315));
    temp_pending.push_back('1);
    queue_random(150);
    drain();

    // extremes: largest coefficients and pc, so the exponent overflows
    load_regs(2097151, 2097151, 2097151, 2097151, 268435455, 1048575);
    temp_pending.push_back(TEMP_W'(1));
    temp_pending.push_back(TEMP_W'(1048574));
    temp_pending.push_back('1);
    queue_random(90);
    drain();

    // most negative coefficients drive the exponent to the floor
    load_regs(-2097152, -2097152, -2097152, -2097152, 268435455, 1048575);
    temp_pending.push_back(TEMP_W'(1));
    temp_pending.push_back(TEMP_W'(1048000));
    queue_random(90);
    drain();

    // tc of one lsb; also an unmapped address that must be ignored
    load_regs(65536, 0, 0, 0, 1, 1);
    reg_write(6, 32'hFFFF_FFFF);
    temp_pending.push_back('0);
    temp_pending.push_back(TEMP_W'(1));
    queue_random(30);
    drain();

    // zero critical temperature acts as zero temperature
    reg_write(REG_CRIT_T, 0);
    queue_random(20);
    drain();

    // long stretch with no idling on either side
    no_idle = 1'b1;
    load_regs(-515081, 120854, -772455, 1486406, 22064000, 662630);
    queue_random(150);
    drain();
    no_idle = 1'b0;

    // random register settings with mild coefficients, then anything goes
    for (int p = 0; p < 6; p++) begin
      if (p < 4)
        load_regs(longint'($urandom_range(800000)) - 900000, $urandom_range(300000),
                  longint'($urandom_range(1600000)) - 800000,
                  longint'($urandom_range(3000000)) - 1500000,
                  $urandom_range(268435455), $urandom_range(1048575, 1));
      else
        load_regs(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(),
                  $urandom_range(268435455), $urandom_range(1048575, 1));
      queue_random(60);
      drain();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d temperature beats, %0d results, %0d saturated, %0d zero-temperature",
             beats_in, beats_out, sat_seen, zt_seen);
    $display("register phases spanned reset values, water constants and coefficient extremes");
    if (mismatches == 0 && pres_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (pres_expected.size() != 0) report_mismatch("predicted beats never arrived");
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== wagner_vapor_pressure_eval_top.f =====
rtl/core/wvp_pkg.sv
rtl/core/wagner_vapor_pressure_eval_top.sv
verif/wagner_vapor_pressure_eval_top_tb.sv
